>>> rtl/wrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg
// Types and constants shared by the Wilder RSI stream block and its checker.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned RSI_W    = 23;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd14;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 11'd2047;
    localparam logic [RSI_W-1:0]    RSI_FULL     = 23'd6553600;
    // 6553600 = 100 * 2^16, so the ratio numerator is (gain * 100) << 16.
    localparam logic [PERIOD_W-1:0] RSI_SCALE    = 10'd100;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_AVG_G,
        ST_AVG_L,
        ST_MUL_G,
        ST_DIV_G,
        ST_MUL_L,
        ST_DIV_L,
        ST_RAT_M,
        ST_RAT_D,
        ST_FIN
    } wrs_state_t;

endpackage

>>> rtl/wilder_rsi_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilder_rsi_stream
// Relative strength index with Wilder smoothing over a stream of closing
// prices, built around a bit-serial multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// A clear or warm-up beat goes from ST_PREP straight to ST_FIN; once smoothing
// runs, the beat also passes through the restoring divider (one quotient bit per
// cycle, 48 bits per division by period, 23 bits for the ratio) and the
// shift-add multiplier (one multiplier bit per cycle). Throughput: one beat
// in flight; the next is taken once the result is in the output register.
// Reset clears the FSM, count, averages and last price and sets period to 14.
module wilder_rsi_stream
    import wrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] close_price
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [22:0] rsi_value, [23] zero
    output logic [0:0]  m_tuser    // [0] rsi_valid
);

    wrs_state_t state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ACC_W-1:0]    avg_gain_reg, avg_gain_next;
    logic [ACC_W-1:0]    avg_loss_reg, avg_loss_next;
    logic [PRICE_W-1:0]  prev_reg, prev_next;
    logic                action_reg, action_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [ACC_W-1:0]    gain_reg, gain_next;
    logic [ACC_W-1:0]    loss_reg, loss_next;
    logic [RSI_W-1:0]    res_value_reg, res_value_next;
    logic                res_valid_reg, res_valid_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [RSI_W-1:0]    m_value_reg, m_value_next;
    logic                m_flag_reg, m_flag_next;

    // Divider: remainder, remaining dividend bits (MSB first), quotient.
    logic [48:0] div_rem_reg, div_rem_next;
    logic [71:0] div_num_reg, div_num_next;
    logic [47:0] div_quo_reg, div_quo_next;
    logic [48:0] div_den_reg, div_den_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    // Multiplier: accumulator, shifted multiplicand, remaining multiplier.
    logic [58:0] mul_acc_reg, mul_acc_next;
    logic [56:0] mul_a_reg, mul_a_next;
    logic [PERIOD_W-1:0] mul_b_reg, mul_b_next;

    logic        div_load, div_long;
    logic [71:0] div_x;
    logic [48:0] div_den_in;
    logic        mul_load;
    logic [ACC_W-1:0]    mul_x, mul_add;
    logic [PERIOD_W-1:0] mul_m;

    logic [PERIOD_W-1:0] pe, pm1;
    logic [COUNT_W-1:0]  p1, p2, cnt_inc;
    logic [PRICE_W-1:0]  diff;
    logic [ACC_W:0]      sum_g, sum_l;
    logic [49:0]         div_try;
    logic                div_done, mul_done;

    assign pe       = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign pm1      = pe - PERIOD_W'(1);
    assign p1       = COUNT_W'(pe) + COUNT_W'(1);
    assign p2       = COUNT_W'(pe) + COUNT_W'(2);
    assign cnt_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    assign diff     = (price_reg > prev_reg) ? price_reg - prev_reg : prev_reg - price_reg;
    assign sum_g    = {1'b0, avg_gain_reg}
                    + ((price_reg > prev_reg) ? {1'b0, diff, 16'd0} : '0);
    assign sum_l    = {1'b0, avg_loss_reg}
                    + ((price_reg > prev_reg) ? '0 : {1'b0, diff, 16'd0});
    assign div_try  = {div_rem_reg, div_num_reg[71]};
    assign div_done = (div_cnt_reg == '0);
    assign mul_done = (mul_b_reg == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_value_reg};
    assign m_tuser  = m_flag_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        avg_gain_next  = avg_gain_reg;
        avg_loss_next  = avg_loss_reg;
        prev_next      = prev_reg;
        action_next    = action_reg;
        price_next     = price_reg;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        res_value_next = res_value_reg;
        res_valid_next = res_valid_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_value_next   = m_value_reg;
        m_flag_next    = m_flag_reg;
        div_load       = 1'b0;
        div_long       = 1'b1;
        div_x          = '0;
        div_den_in     = 49'(pe);
        mul_load       = 1'b0;
        mul_x          = '0;
        mul_m          = pm1;
        mul_add        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    action_next = s_tuser[0];
                    price_next  = s_tdata;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                res_value_next = '0;
                res_valid_next = 1'b0;
                if (action_reg == ACT_CLEAR)
                begin
                    count_next    = '0;
                    avg_gain_next = '0;
                    avg_loss_next = '0;
                    prev_next     = '0;
                    state_next    = ST_FIN;
                end
                else if (count_reg == '0)
                begin
                    count_next = COUNT_W'(1);
                    prev_next  = price_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    count_next = cnt_inc;
                    prev_next  = price_reg;
                    if (price_reg > prev_reg)
                    begin
                        gain_next = {diff, 16'd0};
                        loss_next = '0;
                    end
                    else
                    begin
                        gain_next = '0;
                        loss_next = {diff, 16'd0};
                    end
                    if (cnt_inc <= p1)
                    begin
                        // Warm-up: saturating sums of gains and losses.
                        avg_gain_next = sum_g[ACC_W] ? '1 : sum_g[ACC_W-1:0];
                        avg_loss_next = sum_l[ACC_W] ? '1 : sum_l[ACC_W-1:0];
                        state_next    = ST_FIN;
                    end
                    else if (cnt_inc == p2)
                    begin
                        div_load   = 1'b1;
                        div_x      = 72'(avg_gain_reg);
                        state_next = ST_AVG_G;
                    end
                    else
                    begin
                        mul_load   = 1'b1;
                        mul_x      = avg_gain_reg;
                        mul_add    = gain_next;
                        state_next = ST_MUL_G;
                    end
                end
            end
            ST_AVG_G:
            begin
                if (div_done)
                begin
                    avg_gain_next = div_quo_reg;
                    div_load      = 1'b1;
                    div_x         = 72'(avg_loss_reg);
                    state_next    = ST_AVG_L;
                end
            end
            ST_AVG_L:
            begin
                if (div_done)
                begin
                    avg_loss_next = div_quo_reg;
                    mul_load      = 1'b1;
                    mul_x         = avg_gain_reg;
                    mul_add       = gain_reg;
                    state_next    = ST_MUL_G;
                end
            end
            ST_MUL_G:
            begin
                if (mul_done)
                begin
                    div_load   = 1'b1;
                    div_x      = 72'(mul_acc_reg);
                    state_next = ST_DIV_G;
                end
            end
            ST_DIV_G:
            begin
                if (div_done)
                begin
                    avg_gain_next = div_quo_reg;
                    mul_load      = 1'b1;
                    mul_x         = avg_loss_reg;
                    mul_add       = loss_reg;
                    state_next    = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                if (mul_done)
                begin
                    div_load   = 1'b1;
                    div_x      = 72'(mul_acc_reg);
                    state_next = ST_DIV_L;
                end
            end
            ST_DIV_L:
            begin
                if (div_done)
                begin
                    avg_loss_next = div_quo_reg;
                    if (div_quo_reg == '0)
                    begin
                        res_value_next = RSI_FULL;
                        res_valid_next = 1'b1;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        mul_load   = 1'b1;
                        mul_x      = avg_gain_reg;
                        mul_m      = RSI_SCALE;
                        state_next = ST_RAT_M;
                    end
                end
            end
            ST_RAT_M:
            begin
                if (mul_done)
                begin
                    // The quotient is below 2^23, so 23 steps suffice.
                    div_load   = 1'b1;
                    div_long   = 1'b0;
                    div_x      = {mul_acc_reg[55:0], 16'd0};
                    div_den_in = {1'b0, avg_gain_reg} + {1'b0, avg_loss_reg};
                    state_next = ST_RAT_D;
                end
            end
            ST_RAT_D:
            begin
                if (div_done)
                begin
                    res_value_next = div_quo_reg[RSI_W-1:0];
                    res_valid_next = 1'b1;
                    state_next     = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = res_value_reg;
                    m_flag_next   = res_valid_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Restoring divider, one quotient bit per cycle.
        div_rem_next = div_rem_reg;
        div_num_next = div_num_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        if (div_load)
        begin
            div_quo_next = '0;
            div_den_next = div_den_in;
            if (div_long)
            begin
                div_rem_next = 49'(div_x[71:48]);
                div_num_next = {div_x[47:0], 24'd0};
                div_cnt_next = 6'd48;
            end
            else
            begin
                div_rem_next = div_x[71:23];
                div_num_next = {div_x[22:0], 49'd0};
                div_cnt_next = 6'd23;
            end
        end
        else if (!div_done)
        begin
            if (div_try >= {1'b0, div_den_reg})
            begin
                div_rem_next = 49'(div_try - {1'b0, div_den_reg});
                div_quo_next = {div_quo_reg[46:0], 1'b1};
            end
            else
            begin
                div_rem_next = div_try[48:0];
                div_quo_next = {div_quo_reg[46:0], 1'b0};
            end
            div_num_next = {div_num_reg[70:0], 1'b0};
            div_cnt_next = div_cnt_reg - 6'd1;
        end

        // Shift-add multiplier, one multiplier bit per cycle.
        mul_acc_next = mul_acc_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        if (mul_load)
        begin
            mul_acc_next = 59'(mul_add);
            mul_a_next   = 57'(mul_x);
            mul_b_next   = mul_m;
        end
        else if (!mul_done)
        begin
            if (mul_b_reg[0])
            begin
                mul_acc_next = mul_acc_reg + 59'(mul_a_reg);
            end
            mul_a_next = {mul_a_reg[55:0], 1'b0};
            mul_b_next = {1'b0, mul_b_reg[PERIOD_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RESET;
            count_reg     <= '0;
            avg_gain_reg  <= '0;
            avg_loss_reg  <= '0;
            prev_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            mul_b_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            avg_gain_reg  <= avg_gain_next;
            avg_loss_reg  <= avg_loss_next;
            prev_reg      <= prev_next;
            m_tvalid_reg  <= m_tvalid_next;
            div_cnt_reg   <= div_cnt_next;
            mul_b_reg     <= mul_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        price_reg     <= price_next;
        gain_reg      <= gain_next;
        loss_reg      <= loss_next;
        res_value_reg <= res_value_next;
        res_valid_reg <= res_valid_next;
        m_value_reg   <= m_value_next;
        m_flag_reg    <= m_flag_next;
        div_rem_reg   <= div_rem_next;
        div_num_reg   <= div_num_next;
        div_quo_reg   <= div_quo_next;
        div_den_reg   <= div_den_next;
        mul_acc_reg   <= mul_acc_next;
        mul_a_reg     <= mul_a_next;
    end

endmodule

>>> rtl/wrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_checker
// Port-level checks for the Wilder RSI stream block, bound to its top level.
// ----------------------------------------------------------------------------
module wrs_checker
    import wrs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Only one beat is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a beat is still being worked on");

    // A result that is not yet valid carries a zero value.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("warm-up result carries a non-zero value");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23] == 1'b0 && m_tdata[22:0] <= RSI_FULL))
        else $error("RSI value above 100");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output beat changed");

endmodule

bind wilder_rsi_stream wrs_checker u_wrs_checker (.*);
